@@ rtl/rdc_pkg.sv @@
// rdc_pkg: widths, limits, command and state types for the radix digit converter
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package rdc_pkg;

    // payload widths
    localparam int VALUE_W = 31;
    localparam int BASE_W  = 7;
    localparam int DIGIT_W = 6;

    // radix limits
    localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(64);

    // digit stack, deep enough for a full 31-bit value in base 2
    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // divider iteration counter
    localparam int DIV_CW = $clog2(VALUE_W);

    // request class decided by the front
    typedef enum logic [1:0] {
        KIND_BAD,
        KIND_ZERO,
        KIND_CONV
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [VALUE_W-1:0]   value;
        logic [BASE_W-1:0]    base;
    } t_cmd;

    // divider control and status
    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   dividend;
        logic [BASE_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quot;
        logic [DIGIT_W-1:0]   rem;
    } t_div_rsp;

    // back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ONE,
        ST_DIV,
        ST_POP_RD,
        ST_POP_OUT
    } t_back_state;

endpackage

@@ rtl/rdc_ifs.sv @@
// rdc_ifs: valid/ready channel interfaces for input requests, commands and digits
// depends on rdc_pkg
`timescale 1ns / 1ps

interface rdc_in_if import rdc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   value;
    logic [BASE_W-1:0]    base;

    modport source (output valid, value, base, input ready);
    modport sink   (input valid, value, base, output ready);
endinterface

interface rdc_cmd_if import rdc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_cmd   cmd;

    modport source (output valid, cmd, input ready);
    modport sink   (input valid, cmd, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DIGIT_W-1:0]   digit;
    logic                 last;
    logic                 bad_base;

    modport source (output valid, digit, last, bad_base, input ready);
    modport sink   (input valid, digit, last, bad_base, output ready);
endinterface

@@ rtl/radix_digit_converter_unit.sv @@
// radix_digit_converter_unit: top level, front classifier, command queue, divide/stack back end
// depends on rdc_pkg, rdc_ifs, rdc_front, rdc_queue, rdc_back
//
//  port     dir   payload                    role
//  i_in     sink  value[30:0], base[6:0]     conversion request
//  o_out    src   digit[5:0], last, bad_base one digit, most significant first
//
// a value is divided by the base once per digit and each remainder is pushed on a
// stack, then popped as digits (up to 31 digits in base 2); a zero value or a bad base
// skips the divider and gives a single digit. the divider yields one quotient bit per cycle.
// reset is synchronous, active low, and clears all control state; no clearing pass
// the front and a two-deep command queue keep taking requests until full while the back end
// works or waits on o_out.ready; the output register holds a digit until taken
`timescale 1ns / 1ps

module radix_digit_converter_unit import rdc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rdc_in_if.sink        i_in,
    rdc_out_if.source     o_out
);

    rdc_cmd_if u_front_cmd ();
    rdc_cmd_if u_back_cmd ();

    rdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (u_front_cmd.source)
    );

    rdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_front_cmd.sink),
        .o_cmd   (u_back_cmd.source)
    );

    rdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_back_cmd.sink),
        .o_out   (o_out)
    );

endmodule

@@ rtl/rdc_front.sv @@
// rdc_front: accepts requests, classifies them and clamps the base
// depends on rdc_pkg and rdc_ifs
`timescale 1ns / 1ps

module rdc_front import rdc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rdc_in_if.sink        i_in,
    rdc_cmd_if.source     o_cmd
);

    logic   r_valid;
    t_cmd   r_cmd;
    t_cmd   n_cmd;
    logic   in_fire;

    assign i_in.ready = !r_valid || o_cmd.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    // classify the request and saturate the base
    always_comb begin
        n_cmd.value = i_in.value;
        n_cmd.base  = (i_in.base > MAX_BASE) ? MAX_BASE : i_in.base;
        if (i_in.base < MIN_BASE) begin
            n_cmd.kind = KIND_BAD;
        end else if (i_in.value == '0) begin
            n_cmd.kind = KIND_ZERO;
        end else begin
            n_cmd.kind = KIND_CONV;
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_fire) begin
            r_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd.valid = r_valid;
    assign o_cmd.cmd   = r_cmd;

endmodule

@@ rtl/rdc_queue.sv @@
// rdc_queue: short command fifo that decouples the front from the back
// depends on rdc_pkg and rdc_ifs
`timescale 1ns / 1ps

module rdc_queue import rdc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rdc_cmd_if.sink       i_cmd,
    rdc_cmd_if.source     o_cmd
);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;
    logic                 push;
    logic                 pop;

    assign i_cmd.ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.cmd   = r_mem[r_rd_ptr];
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = o_cmd.valid && o_cmd.ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd.cmd;
        end
    end

endmodule

@@ rtl/rdc_divider.sv @@
// rdc_divider: restoring divider, one quotient bit per cycle, 31-bit value by base
// depends on rdc_pkg
`timescale 1ns / 1ps

module rdc_divider import rdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CW-1:0]    r_cnt;
    logic [VALUE_W-1:0]   r_quot;
    logic [DIGIT_W-1:0]   r_rem;
    logic [BASE_W-1:0]    r_div;
    logic [BASE_W-1:0]    trial;
    logic [BASE_W-1:0]    diff;
    logic                 fits;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_quot[VALUE_W-1]};
        fits  = (trial >= r_div);
        diff  = trial - r_div;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_busy <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
            r_cnt  <= DIV_CW'(VALUE_W - 1);
        end else if (r_busy) begin
            r_quot <= {r_quot[VALUE_W-2:0], fits};
            r_rem  <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

@@ rtl/rdc_back.sv @@
// rdc_back: runs the divide loop, stacks remainders and pops them as digits
// depends on rdc_pkg, rdc_ifs and rdc_divider
`timescale 1ns / 1ps

module rdc_back import rdc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rdc_cmd_if.sink       i_cmd,
    rdc_out_if.source     o_out
);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [STACK_CW-1:0]  r_count;
    logic [STACK_CW-1:0]  n_count;
    logic [VALUE_W-1:0]   r_quot;
    logic [VALUE_W-1:0]   n_quot;
    logic [BASE_W-1:0]    r_base;
    logic [BASE_W-1:0]    n_base;
    logic                 r_one_bad;
    logic                 n_one_bad;

    logic [DIGIT_W-1:0]   r_stack [STACK_DEPTH];
    logic [DIGIT_W-1:0]   r_rd_data;
    logic                 wr_en;
    logic                 rd_en;
    logic [STACK_AW-1:0]  rd_addr;
    logic [STACK_CW-1:0]  count_dec;

    logic                 r_out_valid;
    logic [DIGIT_W-1:0]   r_out_digit;
    logic                 r_out_last;
    logic                 r_out_bad;
    logic                 out_free;
    logic                 load_out;
    logic [DIGIT_W-1:0]   n_out_digit;
    logic                 n_out_last;
    logic                 n_out_bad;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    rdc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free  = !r_out_valid || o_out.ready;
    assign count_dec = r_count - 1'b1;
    assign rd_addr   = count_dec[STACK_AW-1:0];

    // sequencer: next state and controls
    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_quot           = r_quot;
        n_base           = r_base;
        n_one_bad        = r_one_bad;
        i_cmd.ready      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_quot;
        div_req.divisor  = r_base;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        load_out         = 1'b0;
        n_out_digit      = r_rd_data;
        n_out_last       = 1'b0;
        n_out_bad        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    case (i_cmd.cmd.kind)
                        KIND_CONV: begin
                            n_base           = i_cmd.cmd.base;
                            n_quot           = i_cmd.cmd.value;
                            n_count          = '0;
                            div_req.start    = 1'b1;
                            div_req.dividend = i_cmd.cmd.value;
                            div_req.divisor  = i_cmd.cmd.base;
                            n_state          = ST_DIV;
                        end
                        default: begin
                            n_one_bad = (i_cmd.cmd.kind == KIND_BAD);
                            n_state   = ST_ONE;
                        end
                    endcase
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_digit = '0;
                    n_out_last  = 1'b1;
                    n_out_bad   = r_one_bad;
                    n_state     = ST_IDLE;
                end
            end
            ST_DIV: begin
                // push the remainder, divide again while the quotient is nonzero
                if (div_rsp.done) begin
                    if (r_count < STACK_CW'(STACK_DEPTH)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    n_quot = div_rsp.quot;
                    if (div_rsp.quot == '0) begin
                        n_state = ST_POP_RD;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quot;
                    end
                end
            end
            ST_POP_RD: begin
                rd_en   = 1'b1;
                n_count = count_dec;
                n_state = ST_POP_OUT;
            end
            ST_POP_OUT: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_digit = r_rd_data;
                    n_out_last  = (r_count == '0);
                    n_state     = (r_count == '0) ? ST_IDLE : ST_POP_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_quot    <= '0;
            r_base    <= '0;
            r_one_bad <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_quot    <= n_quot;
            r_base    <= n_base;
            r_one_bad <= n_one_bad;
        end
    end

    // digit stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[r_count[STACK_AW-1:0]] <= div_rsp.rem;
        end
        if (rd_en) begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_digit <= n_out_digit;
            r_out_last  <= n_out_last;
            r_out_bad   <= n_out_bad;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.digit    = r_out_digit;
    assign o_out.last     = r_out_last;
    assign o_out.bad_base = r_out_bad;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= STACK_CW'(VALUE_W))
        else $error("digit stack count beyond worst case");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> ({1'b0, div_rsp.rem} < r_base))
        else $error("remainder not below base");

    a_bad_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_last && (r_out_digit == '0)))
        else $error("bad base result not a single zero digit");

endmodule
